/* hdl/itfa_pkg.sv */
// Shared types and constants of the interval table first-fit allocator.
package itfa_pkg;

  localparam int ADDR_W     = 32;
  localparam int ITEM_W     = 16;
  localparam int ACT_W      = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 1;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam logic [ADDR_W-1:0] HEAP_START_RST  = 32'h0010_0000;
  localparam logic [ADDR_W-1:0] SEARCH_SPAN_RST = 32'h0010_0000;

  typedef logic [4:0] idx_out_t;

  // Request codes.
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOSPACE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_SPAN = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_CAND,
    S_SCAN,
    S_SHIFT
  } state_t;

endpackage

/* hdl/interval_table_first_fit_allocator_core.sv */
// Top level of the interval table first-fit allocator.
//
// The block keeps a table of up to TABLE_DEPTH allocated blocks, each an
// inclusive range from its start to start plus size, in one RAM that is read
// one entry per cycle. A word is accepted on a rising edge with start high and
// busy low; busy then stays high until the result word has been issued. The
// result appears for exactly one cycle with out_valid high, and the receiver
// has no way to stall it, so it must take every word as it comes. An allocate
// request first dispatches and forms the size product, then for each candidate
// start checks span and overflow and scans the table; a conflict restarts the
// scan at the address just past the conflicting entry. An allocate is only
// searched with fewer than TABLE_DEPTH entries present, and each entry can turn
// away at most one candidate. Free and query requests scan until the matching
// start is found; a free then moves every later entry down one place, one entry
// per cycle. A full table or an action code of three ends at dispatch, and a
// lookup that finds nothing ends once the scan passes the last entry. The table
// RAM has one read and one write port, and every scan runs over that single
// read port. Configuration writes to heap_start and search_span are always
// accepted and should be made only while the block is idle. Table contents need
// no clearing after reset: only entries below the entry count are read.
module interval_table_first_fit_allocator_core #(
  parameter int TABLE_DEPTH = itfa_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel.
  input  logic                               start,
  output logic                               busy,
  input  logic [itfa_pkg::ACT_W-1:0]         in_action,
  input  logic [itfa_pkg::ITEM_W-1:0]        in_item_count,
  input  logic [itfa_pkg::ITEM_W-1:0]        in_item_size,
  input  logic [itfa_pkg::ADDR_W-1:0]        in_block_address,
  // Result channel.
  output logic                               out_valid,
  output logic [itfa_pkg::ADDR_W-1:0]        out_start_address,
  output logic [itfa_pkg::ADDR_W-1:0]        out_block_size,
  output itfa_pkg::idx_out_t                 out_entry_index,
  output logic [itfa_pkg::STAT_W-1:0]        out_status,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [itfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [itfa_pkg::ADDR_W-1:0]        cfg_data
);

  localparam int AW    = itfa_pkg::ADDR_W;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = 2 * AW;

  itfa_pkg::state_t state_r, state_nxt;

  // Latched request.
  logic [itfa_pkg::ACT_W-1:0]  act_r;
  logic [itfa_pkg::ITEM_W-1:0] cnt_r;
  logic [itfa_pkg::ITEM_W-1:0] isz_r;
  logic [AW-1:0]               addr_r;

  // Search state.
  logic [AW-1:0]   size_r, size_nxt;
  logic [AW:0]     s_r, s_nxt;
  logic [AW-1:0]   e_r, e_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Configuration registers.
  logic [AW-1:0] heap_r, span_r;

  // Result registers.
  logic                        out_valid_r, out_valid_nxt;
  logic [AW-1:0]               out_start_r, out_start_nxt;
  logic [AW-1:0]               out_size_r, out_size_nxt;
  itfa_pkg::idx_out_t          out_idx_r, out_idx_nxt;
  logic [itfa_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;

  // Table RAM: each entry holds the start in the upper half, the end below.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  logic [AW-1:0]    rd_start, rd_end;

  itfa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_start = ram_rdata[ENT_W-1:AW];
  assign rd_end   = ram_rdata[AW-1:0];

  // Overlap test of the candidate range against the entry just read. Ranges
  // are inclusive, and a zero address on either side never conflicts.
  logic conflict, match, issue, scan_end;
  logic [AW:0]   span_eff, offset;
  logic [AW+1:0] cand_end;

  assign conflict = cmp_vld_r && (s_r[AW-1:0] != '0) && (e_r != '0) &&
                    (rd_start != '0) && (rd_end != '0) &&
                    (s_r[AW-1:0] <= rd_end) && (e_r >= rd_start);
  assign match    = cmp_vld_r && (rd_start == addr_r);
  assign issue    = (rd_idx_r < count_r);
  assign scan_end = (rd_idx_r == count_r);

  // A zero span still tries heap_start itself.
  assign span_eff = (span_r == '0) ? (AW + 1)'(1) : {1'b0, span_r};
  assign offset   = s_r - {1'b0, heap_r};
  assign cand_end = {1'b0, s_r} + {2'b00, size_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itfa_pkg::S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      heap_r      <= itfa_pkg::HEAP_START_RST;
      span_r      <= itfa_pkg::SEARCH_SPAN_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          itfa_pkg::CFG_HEAP_START:  heap_r <= cfg_data;
          itfa_pkg::CFG_SEARCH_SPAN: span_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_r  <= in_action;
      cnt_r  <= in_item_count;
      isz_r  <= in_item_size;
      addr_r <= in_block_address;
    end
    size_r      <= size_nxt;
    s_r         <= s_nxt;
    e_r         <= e_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    res_idx_r   <= res_idx_nxt;
    out_start_r <= out_start_nxt;
    out_size_r  <= out_size_nxt;
    out_idx_r   <= out_idx_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    res_idx_nxt   = res_idx_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_start_nxt = out_start_r;
    out_size_nxt  = out_size_r;
    out_idx_nxt   = out_idx_r;
    out_stat_nxt  = out_stat_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[IDX_W-1:0];
    ram_wdata     = {s_r[AW-1:0], e_r};

    unique case (state_r)
      itfa_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = itfa_pkg::S_DISP;
        end
      end

      itfa_pkg::S_DISP: begin
        // Failure results carry a zero address and size and the entry count.
        out_start_nxt = '0;
        out_size_nxt  = '0;
        out_idx_nxt   = itfa_pkg::idx_out_t'(count_r);
        rd_idx_nxt    = '0;
        case (act_r) inside
          itfa_pkg::ACT_ALLOC: begin
            if (count_r == CNT_W'(TABLE_DEPTH)) begin
              out_stat_nxt  = itfa_pkg::STAT_FULL;
              out_valid_nxt = 1'b1;
              state_nxt     = itfa_pkg::S_IDLE;
            end else begin
              size_nxt  = AW'(cnt_r) * AW'(isz_r);
              s_nxt     = {1'b0, heap_r};
              state_nxt = itfa_pkg::S_CAND;
            end
          end
          itfa_pkg::ACT_FREE, itfa_pkg::ACT_QUERY: begin
            state_nxt = itfa_pkg::S_SCAN;
          end
          default: begin
            out_stat_nxt  = itfa_pkg::STAT_NOTFOUND;
            out_valid_nxt = 1'b1;
            state_nxt     = itfa_pkg::S_IDLE;
          end
        endcase
      end

      itfa_pkg::S_CAND: begin
        // Give up once the offset leaves the span or the end would wrap.
        if (offset >= span_eff || cand_end[AW+1:AW] != 2'b00) begin
          out_stat_nxt  = itfa_pkg::STAT_NOSPACE;
          out_valid_nxt = 1'b1;
          state_nxt     = itfa_pkg::S_IDLE;
        end else begin
          e_nxt      = cand_end[AW-1:0];
          rd_idx_nxt = '0;
          state_nxt  = itfa_pkg::S_SCAN;
        end
      end

      itfa_pkg::S_SCAN: begin
        if (act_r == itfa_pkg::ACT_ALLOC) begin
          if (conflict) begin
            // Every start up to the conflicting entry's end still overlaps it.
            s_nxt     = {1'b0, rd_end} + (AW + 1)'(1);
            state_nxt = itfa_pkg::S_CAND;
          end else if (scan_end) begin
            ram_we        = 1'b1;
            count_nxt     = count_r + CNT_W'(1);
            out_start_nxt = s_r[AW-1:0];
            out_stat_nxt  = itfa_pkg::STAT_OK;
            out_valid_nxt = 1'b1;
            state_nxt     = itfa_pkg::S_IDLE;
          end else begin
            cmp_vld_nxt = 1'b1;
            cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
            rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          end
        end else begin
          if (match && act_r == itfa_pkg::ACT_QUERY) begin
            out_size_nxt  = rd_end - rd_start;
            out_idx_nxt   = itfa_pkg::idx_out_t'(cmp_idx_r);
            out_stat_nxt  = itfa_pkg::STAT_OK;
            out_valid_nxt = 1'b1;
            state_nxt     = itfa_pkg::S_IDLE;
          end else if (match) begin
            // Keep the read pipeline running: it feeds the shift directly.
            res_idx_nxt = cmp_idx_r;
            state_nxt   = itfa_pkg::S_SHIFT;
            if (issue) begin
              cmp_vld_nxt = 1'b1;
              cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
              rd_idx_nxt  = rd_idx_r + CNT_W'(1);
            end
          end else if (scan_end) begin
            out_stat_nxt  = itfa_pkg::STAT_NOTFOUND;
            out_valid_nxt = 1'b1;
            state_nxt     = itfa_pkg::S_IDLE;
          end else begin
            cmp_vld_nxt = 1'b1;
            cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
            rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          end
        end
      end

      itfa_pkg::S_SHIFT: begin
        // Each entry read is written back one place lower.
        if (cmp_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = cmp_idx_r - IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        if (scan_end) begin
          count_nxt     = count_r - CNT_W'(1);
          out_idx_nxt   = itfa_pkg::idx_out_t'(res_idx_r);
          out_stat_nxt  = itfa_pkg::STAT_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = itfa_pkg::S_IDLE;
        end else begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        end
      end

      default: begin
        state_nxt = itfa_pkg::S_IDLE;
      end
    endcase
  end

  assign busy              = (state_r != itfa_pkg::S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_start_address = out_start_r;
  assign out_block_size    = out_size_r;
  assign out_entry_index   = out_idx_r;
  assign out_status        = out_stat_r;

  // The result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // An accepted word always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start processing");

  // The table never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // The entry count only changes together with an issued result.
  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |-> out_valid)
    else $error("entry count changed without a result");

  // Scans never read past the last valid entry.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itfa_pkg::S_SCAN || state_r == itfa_pkg::S_SHIFT) |->
      rd_idx_r <= count_r)
    else $error("table read beyond entry count");

endmodule

/* hdl/itfa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module itfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
